// ===== sv/tkmh_pkg.sv =====
`timescale 1ns / 1ps

package tkmh_pkg;

    // Fixed widths of the channel fields
    localparam int RES_VALUE_W = 32;
    localparam int ENTRY_IDX_W = 4;
    localparam int ENTRIES_W   = 5;
    localparam int K_W         = 5;

    // Register index and request codes
    localparam logic REG_K_IN_USE = 1'b0;
    localparam logic REQ_OFFER    = 1'b0;
    localparam logic REQ_DUMP     = 1'b1;

    // Root reported for an empty store (-1)
    localparam logic [RES_VALUE_W-1:0] EMPTY_ROOT = '1;

    // Reset value of k_in_use
    localparam logic [K_W-1:0] K_RESET = 5'd4;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] sample_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         entry_index;
        logic [4:0]         entries_held;
        logic               last_of_run;
    } result_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPEND,
        OP_RD_ROOT,
        OP_REPLACE,
        OP_HEAP_INIT,
        OP_HEAP_NEXT,
        OP_HEAP_LOAD,
        OP_SIFT,
        OP_EMIT_ROOT,
        OP_DUMP_EMPTY,
        OP_DUMP_START,
        OP_DUMP_STEP
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic can_append;
        logic at_k;
        logic beats_root;
        logic j_zero;
        logic sift_done;
        logic fill_zero;
        logic dump_last;
    } status_t;

endpackage

// ===== sv/top_k_min_heap_top.sv =====
`timescale 1ns / 1ps

// Top-k selector: keeps the k largest signed values offered, as a min-heap.
// Request channel: drive req and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. req_type 0 offers
// sample_value, req_type 1 dumps the store in array order.
// Result channel: result_strobe is high for one cycle per result; the
// receiver cannot stall it, so it must take every result as it comes.
// An offer gives one result: the root (smallest kept value) and the fill
// count. A dump gives one result per stored entry, last_of_run on the final
// one; an empty store dumps a single -1 result.
// An offer that appends writes the value at the end of the store; one that
// loses against the root leaves the store as it is; a replacement writes
// over the root and sifts it down the heap. The offer that fills the store
// to k runs the bottom-up heapify, sifting down each interior node in turn.
// The single memory write port and its registered reads set one heap level
// per cycle. One transaction at a time: busy drops while the last result is
// on the ports, so the next request can be taken at the edge that ends it.
// k_in_use is written over the APB port (reset 4). Reset empties the store;
// the store contents themselves are not cleared.
module top_k_min_heap_top #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tkmh_pkg::req_t     req,
    output logic               result_strobe,
    output tkmh_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [tkmh_pkg::K_W-1:0] k_reg, k_next;
    logic [CW-1:0]            k_eff;
    logic                     reg_hit;
    tkmh_pkg::cmd_t           cmd;
    tkmh_pkg::status_t        status;

    // Register write decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == tkmh_pkg::REG_K_IN_USE);

    always_comb
    begin
        k_next = k_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            k_next = pwdata[tkmh_pkg::K_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= tkmh_pkg::K_RESET;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    assign prdata = reg_hit ? 32'(k_reg) : '0;

    // Clamp k to the range 1..CAPACITY
    always_comb
    begin
        if (k_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (32'(k_reg) > 32'(CAPACITY))
        begin
            k_eff = CW'(CAPACITY);
        end
        else
        begin
            k_eff = CW'(k_reg);
        end
    end

    tkmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dump_req (req.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    tkmh_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .k_eff         (k_eff),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ===== sv/tkmh_ctrl.sv =====
`timescale 1ns / 1ps

module tkmh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              dump_req,
    input  tkmh_pkg::status_t status,
    output tkmh_pkg::cmd_t    cmd,
    output logic              busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFFER,
        ST_FILLED,
        ST_CMP,
        ST_HNEXT,
        ST_HLOAD,
        ST_SIFT_H,
        ST_SIFT_R,
        ST_ROOT,
        ST_EMIT,
        ST_DUMP,
        ST_DRUN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Sequence the datapath operations
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = tkmh_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = tkmh_pkg::OP_LOAD;
                    state_next = (dump_req == tkmh_pkg::REQ_DUMP) ? ST_DUMP : ST_OFFER;
                end
            end
            ST_OFFER:
            begin
                if (status.can_append)
                begin
                    cmd.op     = tkmh_pkg::OP_APPEND;
                    state_next = ST_FILLED;
                end
                else
                begin
                    cmd.op     = tkmh_pkg::OP_RD_ROOT;
                    state_next = ST_CMP;
                end
            end
            ST_FILLED:
            begin
                if (status.at_k)
                begin
                    cmd.op     = tkmh_pkg::OP_HEAP_INIT;
                    state_next = ST_HNEXT;
                end
                else
                begin
                    cmd.op     = tkmh_pkg::OP_RD_ROOT;
                    state_next = ST_EMIT;
                end
            end
            ST_CMP:
            begin
                if (status.beats_root)
                begin
                    cmd.op     = tkmh_pkg::OP_REPLACE;
                    state_next = ST_SIFT_R;
                end
                else
                begin
                    cmd.op     = tkmh_pkg::OP_EMIT_ROOT;
                    state_next = ST_IDLE;
                end
            end
            ST_HNEXT:
            begin
                if (status.j_zero)
                begin
                    cmd.op     = tkmh_pkg::OP_RD_ROOT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op     = tkmh_pkg::OP_HEAP_NEXT;
                    state_next = ST_HLOAD;
                end
            end
            ST_HLOAD:
            begin
                cmd.op     = tkmh_pkg::OP_HEAP_LOAD;
                state_next = ST_SIFT_H;
            end
            ST_SIFT_H:
            begin
                cmd.op = tkmh_pkg::OP_SIFT;
                if (status.sift_done)
                begin
                    state_next = ST_HNEXT;
                end
            end
            ST_SIFT_R:
            begin
                cmd.op = tkmh_pkg::OP_SIFT;
                if (status.sift_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.op     = tkmh_pkg::OP_RD_ROOT;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.op     = tkmh_pkg::OP_EMIT_ROOT;
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (status.fill_zero)
                begin
                    cmd.op     = tkmh_pkg::OP_DUMP_EMPTY;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op     = tkmh_pkg::OP_DUMP_START;
                    state_next = ST_DRUN;
                end
            end
            ST_DRUN:
            begin
                cmd.op = tkmh_pkg::OP_DUMP_STEP;
                if (status.dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // Hold state and the busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== sv/tkmh_dp.sv =====
`timescale 1ns / 1ps

module tkmh_dp #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tkmh_pkg::req_t                    req,
    input  logic [$clog2(CAPACITY + 1) - 1:0] k_eff,
    input  tkmh_pkg::cmd_t                    cmd,
    output tkmh_pkg::status_t                 status,
    output logic                              result_strobe,
    output tkmh_pkg::result_t                 result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(2 * CAPACITY + 1);
    localparam int XW = VALUE_WIDTH + 32;

    // Heap store: one write port, two registered read ports
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rda_reg, rdb_reg;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   ra_en, rb_en;
    logic [IW-1:0]          ra_idx, rb_idx;

    // Working registers
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [IW-1:0]          pos_reg, pos_next;
    logic [IW-1:0]          didx_reg, didx_next;
    logic [VALUE_WIDTH-1:0] held_reg, held_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic                   strobe_reg, strobe_next;
    tkmh_pkg::result_t      res_reg, res_next;

    // Sift step signals
    logic [IW-1:0]          left_idx, right_idx, child_idx, gl_idx, gr_idx;
    logic                   has_left, has_right, pick_r, sift_stop;
    logic [VALUE_WIDTH-1:0] child_val;

    logic signed [XW-1:0]   in_ext, out_ext;
    logic [IW+3:0]          didx_wide;
    logic [CW+4:0]          fill_wide;
    logic [IW-1:0]          didx_inc;

    function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
        return (idx < IW'(CAPACITY)) ? idx[AW-1:0] : '0;
    endfunction

    // Convert between the 32-bit channel and the stored width
    assign in_ext  = XW'(req.sample_value);
    assign out_ext = XW'($signed(rda_reg));

    assign didx_wide = (IW + 4)'(didx_reg);
    assign fill_wide = (CW + 5)'(fill_reg);
    assign didx_inc  = didx_reg + IW'(1);

    // Compare the held value against the smaller child
    always_comb
    begin
        left_idx  = IW'({pos_reg, 1'b0}) + IW'(1);
        right_idx = left_idx + IW'(1);
        has_left  = left_idx < IW'(fill_reg);
        has_right = right_idx < IW'(fill_reg);
        pick_r    = has_right && ($signed(rdb_reg) < $signed(rda_reg));
        child_val = pick_r ? rdb_reg : rda_reg;
        child_idx = pick_r ? right_idx : left_idx;
        sift_stop = !has_left || ($signed(held_reg) < $signed(child_val));
        gl_idx    = IW'({child_idx, 1'b0}) + IW'(1);
        gr_idx    = gl_idx + IW'(1);
    end

    // Report status to the controller
    always_comb
    begin
        status.can_append = fill_reg < k_eff;
        status.at_k       = fill_reg == k_eff;
        status.beats_root = $signed(v_reg) > $signed(rda_reg);
        status.j_zero     = j_reg == '0;
        status.sift_done  = sift_stop;
        status.fill_zero  = fill_reg == '0;
        status.dump_last  = didx_inc == IW'(fill_reg);
    end

    // Decode the operation
    always_comb
    begin
        we          = 1'b0;
        waddr       = '0;
        wdata       = held_reg;
        ra_en       = 1'b0;
        rb_en       = 1'b0;
        ra_idx      = '0;
        rb_idx      = '0;
        fill_next   = fill_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        didx_next   = didx_reg;
        held_next   = held_reg;
        v_next      = v_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        case (cmd.op)
            tkmh_pkg::OP_LOAD:
            begin
                v_next = in_ext[VALUE_WIDTH-1:0];
            end
            tkmh_pkg::OP_APPEND:
            begin
                we        = 1'b1;
                waddr     = to_addr(IW'(fill_reg));
                wdata     = v_reg;
                fill_next = fill_reg + CW'(1);
            end
            tkmh_pkg::OP_RD_ROOT:
            begin
                ra_en  = 1'b1;
                ra_idx = '0;
            end
            tkmh_pkg::OP_REPLACE:
            begin
                held_next = v_reg;
                pos_next  = '0;
                ra_en     = 1'b1;
                rb_en     = 1'b1;
                ra_idx    = IW'(1);
                rb_idx    = IW'(2);
            end
            tkmh_pkg::OP_HEAP_INIT:
            begin
                j_next = fill_reg >> 1;
            end
            tkmh_pkg::OP_HEAP_NEXT:
            begin
                pos_next = IW'(j_reg - CW'(1));
                j_next   = j_reg - CW'(1);
                ra_en    = 1'b1;
                ra_idx   = IW'(j_reg - CW'(1));
            end
            tkmh_pkg::OP_HEAP_LOAD:
            begin
                held_next = rda_reg;
                ra_en     = 1'b1;
                rb_en     = 1'b1;
                ra_idx    = left_idx;
                rb_idx    = right_idx;
            end
            tkmh_pkg::OP_SIFT:
            begin
                we    = 1'b1;
                waddr = to_addr(pos_reg);
                if (sift_stop)
                begin
                    wdata = held_reg;
                end
                else
                begin
                    wdata    = child_val;
                    pos_next = child_idx;
                    ra_en    = 1'b1;
                    rb_en    = 1'b1;
                    ra_idx   = gl_idx;
                    rb_idx   = gr_idx;
                end
            end
            tkmh_pkg::OP_EMIT_ROOT:
            begin
                strobe_next           = 1'b1;
                res_next.result_value = out_ext[31:0];
                res_next.entry_index  = '0;
                res_next.entries_held = fill_wide[4:0];
                res_next.last_of_run  = 1'b1;
            end
            tkmh_pkg::OP_DUMP_EMPTY:
            begin
                strobe_next           = 1'b1;
                res_next.result_value = tkmh_pkg::EMPTY_ROOT;
                res_next.entry_index  = '0;
                res_next.entries_held = '0;
                res_next.last_of_run  = 1'b1;
            end
            tkmh_pkg::OP_DUMP_START:
            begin
                ra_en     = 1'b1;
                ra_idx    = '0;
                didx_next = '0;
            end
            tkmh_pkg::OP_DUMP_STEP:
            begin
                strobe_next           = 1'b1;
                res_next.result_value = out_ext[31:0];
                res_next.entry_index  = didx_wide[3:0];
                res_next.entries_held = fill_wide[4:0];
                res_next.last_of_run  = status.dump_last;
                ra_en                 = 1'b1;
                ra_idx                = didx_inc;
                didx_next             = didx_inc;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Write and read the heap store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ra_en)
        begin
            rda_reg <= mem[to_addr(ra_idx)];
        end
        if (rb_en)
        begin
            rdb_reg <= mem[to_addr(rb_idx)];
        end
    end

    // Hold fill count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            strobe_reg <= strobe_next;
        end
    end

    // Advance the working payload registers
    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        pos_reg  <= pos_next;
        didx_reg <= didx_next;
        held_reg <= held_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

// ===== tb/top_k_min_heap_top_test.sv =====
`timescale 1ns / 1ps

module top_k_min_heap_top_test;

    localparam int CAP = 16;
    localparam int KW = tkmh_pkg::K_W;
    localparam int IDX_W = tkmh_pkg::ENTRY_IDX_W;
    localparam int HELD_W = tkmh_pkg::ENTRIES_W;
    localparam logic [2:0] K_ADDR = 3'(tkmh_pkg::REG_K_IN_USE) * 3'd4;
    // first byte address past the register map
    localparam logic [2:0] SPARE_ADDR = 3'd4;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int DUE_DEPTH = 64;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    tkmh_pkg::req_t     req;
    logic               result_strobe;
    tkmh_pkg::result_t  result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Expected block state and outputs still owed
    logic signed [31:0] kept_values [CAP];
    int unsigned        kept_count;
    logic [KW-1:0]      k_setting;
    tkmh_pkg::result_t  due_fifo [DUE_DEPTH];
    int unsigned        due_wr;
    int unsigned        due_rd;
    int                 fail_count;

    top_k_min_heap_top #(
        .CAPACITY    (CAP),
        .VALUE_WIDTH (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .result_strobe (result_strobe),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Queue one owed result behind the others
    function automatic void owe_result(input tkmh_pkg::result_t r);
        due_fifo[due_wr % DUE_DEPTH] = r;
        due_wr++;
    endfunction

    // Clamp k to the built capacity; zero acts as one
    function automatic int unsigned k_effective();
        int unsigned k;
        k = k_setting;
        if (k < 1)
        begin
            k = 1;
        end
        if (k > CAP)
        begin
            k = CAP;
        end
        return k;
    endfunction

    // Sift down: smaller child wins, ties go left, stop above a strictly larger child
    function automatic void sift_down(input int unsigned pos, input int unsigned n);
        logic signed [31:0] held;
        int unsigned        child;
        if (pos >= n)
        begin
            return;
        end
        held  = kept_values[pos];
        child = 2 * pos + 1;
        while (child < n)
        begin
            if (child + 1 < n && kept_values[child + 1] < kept_values[child])
            begin
                child++;
            end
            if (held < kept_values[child])
            begin
                break;
            end
            kept_values[pos] = kept_values[child];
            pos   = child;
            child = 2 * pos + 1;
        end
        kept_values[pos] = held;
    endfunction

    // Update the expected heap for one accepted request and queue its outputs
    function automatic void absorb_request(input tkmh_pkg::req_t item);
        tkmh_pkg::result_t r;
        int unsigned       k;
        k = k_effective();
        if (item.req_type == tkmh_pkg::REQ_OFFER)
        begin
            if (kept_count < k)
            begin
                kept_values[kept_count] = item.sample_value;
                kept_count++;
                if (kept_count == k)
                begin
                    for (int j = kept_count / 2; j > 0; j--)
                    begin
                        sift_down(j - 1, kept_count);
                    end
                end
            end
            else if (kept_count > 0 && item.sample_value > kept_values[0])
            begin
                kept_values[0] = item.sample_value;
                sift_down(0, kept_count);
            end
            r.result_value = (kept_count != 0) ? kept_values[0] : tkmh_pkg::EMPTY_ROOT;
            r.entry_index  = '0;
            r.entries_held = HELD_W'(kept_count);
            r.last_of_run  = 1'b1;
            owe_result(r);
        end
        else if (kept_count == 0)
        begin
            r.result_value = tkmh_pkg::EMPTY_ROOT;
            r.entry_index  = '0;
            r.entries_held = '0;
            r.last_of_run  = 1'b1;
            owe_result(r);
        end
        else
        begin
            for (int unsigned i = 0; i < kept_count; i++)
            begin
                r.result_value = kept_values[i];
                r.entry_index  = IDX_W'(i);
                r.entries_held = HELD_W'(kept_count);
                r.last_of_run  = (i + 1 == kept_count);
                owe_result(r);
            end
        end
    endfunction

    // Compare each strobed result against the oldest one owed
    always @(posedge clk)
    begin
        tkmh_pkg::result_t want;
        if (rst_n && result_strobe)
        begin
            if (due_wr == due_rd)
            begin
                note_failure($sformatf(
                    "unexpected result: value %0d index %0d held %0d last %0b",
                    result.result_value, result.entry_index, result.entries_held,
                    result.last_of_run));
            end
            else
            begin
                want = due_fifo[due_rd % DUE_DEPTH];
                due_rd++;
                if (result.result_value !== want.result_value ||
                    result.entry_index !== want.entry_index ||
                    result.entries_held !== want.entries_held ||
                    result.last_of_run !== want.last_of_run)
                begin
                    // fields are value/index/held/last
                    note_failure($sformatf(
                        "mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                        want.result_value, want.entry_index, want.entries_held,
                        want.last_of_run, result.result_value, result.entry_index,
                        result.entries_held, result.last_of_run));
                end
            end
        end
    end

    // Issue one transaction; start stays high until the next hold-off or drain
    task automatic send_request(input logic req_type, input logic signed [31:0] value);
        tkmh_pkg::req_t item;
        item.req_type     = req_type;
        item.sample_value = value;
        start <= 1'b1;
        req   <= item;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        absorb_request(item);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and wait until every owed result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (due_wr != due_rd)
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    // APB write, then read k back
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (addr == K_ADDR)
        begin
            k_setting = data[KW-1:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= K_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (prdata !== 32'(k_setting))
        begin
            note_failure($sformatf("k readback: expected %0d, got %0d", k_setting, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write k with random upper data bits
    task automatic set_k(input int unsigned k);
        logic [31:0] data;
        data = $urandom;
        data[KW-1:0] = KW'(k);
        write_register(K_ADDR, data);
    endtask

    function automatic logic signed [31:0] pick_sample();
        logic signed [31:0] v;
        int unsigned        roll;
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            v = $urandom;
        end
        else if (roll < 75)
        begin
            v = $signed($urandom_range(32)) - 16;
        end
        else if (roll < 85)
        begin
            case ($urandom_range(3))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7FFF_FFFF;
                2: v = -1;
                default: v = 0;
            endcase
        end
        else
        begin
            // land on or within two of the current root to hit ties
            v = ((kept_count != 0) ? kept_values[0] : 32'sd0) + $signed($urandom_range(4)) - 2;
        end
        return v;
    endfunction

    task automatic test_empty_dump();
        send_request(tkmh_pkg::REQ_DUMP, $urandom);
    endtask

    // k of zero acts as one; writes to an unmapped address are dropped
    task automatic test_k_limits();
        set_k(0);
        send_request(tkmh_pkg::REQ_OFFER, -5);
        send_request(tkmh_pkg::REQ_OFFER, 32'sh8000_0000);
        send_request(tkmh_pkg::REQ_OFFER, 32'sh7FFF_FFFF);
        set_k(1);
        send_request(tkmh_pkg::REQ_OFFER, 0);
        send_request(tkmh_pkg::REQ_OFFER, 32'sh7FFF_FFFF);
        send_request(tkmh_pkg::REQ_DUMP, 0);
        write_register(SPARE_ADDR, 32'd9);
        send_request(tkmh_pkg::REQ_OFFER, 100);
    endtask

    // Append with duplicates up to k, heapify, then one larger offer and a dump
    task automatic test_fill_and_heapify();
        set_k(6);
        send_request(tkmh_pkg::REQ_OFFER, 5);
        send_request(tkmh_pkg::REQ_OFFER, -3);
        send_request(tkmh_pkg::REQ_OFFER, 5);
        send_request(tkmh_pkg::REQ_OFFER, -3);
        send_request(tkmh_pkg::REQ_OFFER, 2);
        send_request(tkmh_pkg::REQ_OFFER, -3);
        send_request(tkmh_pkg::REQ_OFFER, 4);
        send_request(tkmh_pkg::REQ_DUMP, 32'hFFFF_FFFF);
    endtask

    // Lower k below the fill: offers compete over the whole store as it stands
    task automatic test_k_below_fill();
        set_k(2);
        send_request(tkmh_pkg::REQ_OFFER, 1);
        send_request(tkmh_pkg::REQ_OFFER, -100);
        send_request(tkmh_pkg::REQ_DUMP, 0);
    endtask

    task automatic test_random_traffic(input int unsigned k, input int unsigned idle_pct,
                                       input int unsigned count);
        logic req_type;
        set_k(k);
        repeat (count)
        begin
            // idle the sender for a random share of the cycles
            while ($urandom_range(99) < idle_pct)
            begin
                hold_off(1);
            end
            req_type = ($urandom_range(99) < 8) ? tkmh_pkg::REQ_DUMP : tkmh_pkg::REQ_OFFER;
            send_request(req_type, pick_sample());
        end
    endtask

    initial
    begin
        fail_count = 0;
        kept_count = 0;
        due_wr     = 0;
        due_rd     = 0;
        k_setting  = tkmh_pkg::K_RESET;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dump();
        test_k_limits();
        test_fill_and_heapify();
        test_k_below_fill();
        test_random_traffic(8, 21, 50);
        test_random_traffic(16, 45, 50);
        test_random_traffic(31, 0, 45);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** top_k_min_heap_top: PASSED **");
        end
        else
        begin
            $display("** top_k_min_heap_top: FAILED **");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #500000;
        $display("** top_k_min_heap_top: FAILED **");
        $finish;
    end

endmodule
